[rtl/branch_predictor_btb_one_two_bit_assert.svh]
// Assertion helpers for the branch predictor.
`ifndef BRANCH_PREDICTOR_BTB_ONE_TWO_BIT_ASSERT_SVH
`define BRANCH_PREDICTOR_BTB_ONE_TWO_BIT_ASSERT_SVH

// Same-cycle implication.
`define BPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bpbtb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpbtb_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  // instruction words are 8-byte aligned for indexing purposes
  localparam int unsigned PC_SHIFT = 3;
  localparam int unsigned PC_WORD_W = 32 - PC_SHIFT;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_ONE_BIT = 2'd1;
  localparam logic [1:0] MODE_TWO_BIT = 2'd2;

  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  typedef struct packed {
    logic [31:0] branch_pc;
    logic [31:0] branch_target;
    logic        taken_outcome;
  } req_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        entry_hit;
    logic [31:0] predicted_target;
    logic        flush_needed;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] target;
    logic [1:0]  ctr;
  } entry_t;

endpackage

`default_nettype wire

[rtl/bpbtb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpbtb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/bpbtb_slot.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpbtb_slot #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [bpbtb_pkg::PC_WORD_W-1:0]      pc_word,
  output logic                                      done,
  output logic      [$clog2(ENTRIES)-1:0]           slot
);

  import bpbtb_pkg::*;

  localparam int unsigned SW = $clog2(ENTRIES);

  if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2

    assign done = start;
    assign slot = pc_word[SW-1:0];

  end else begin : g_rem

    // remainder taken one nibble per cycle, four compare/subtracts each
    localparam int unsigned XW    = 32;
    localparam int unsigned STEPS = XW / 4;
    localparam int unsigned TW    = SW + 4;
    localparam logic [TW-1:0] N1 = TW'(ENTRIES);
    localparam logic [TW-1:0] N2 = TW'(2 * ENTRIES);
    localparam logic [TW-1:0] N4 = TW'(4 * ENTRIES);
    localparam logic [TW-1:0] N8 = TW'(8 * ENTRIES);
    localparam logic [$clog2(STEPS)-1:0] LAST = $clog2(STEPS)'(STEPS - 1);

    logic [XW-1:0]            xs;
    logic [SW-1:0]            rem;
    logic [SW-1:0]            rem_next;
    logic [$clog2(STEPS)-1:0] cnt;
    logic                     running;
    logic                     done_r;

    always_comb begin
      logic [TW-1:0] t0, t1, t2, t3, t4;
      t0 = {rem, xs[XW-1 -: 4]};
      t1 = (t0 >= N8) ? t0 - N8 : t0;
      t2 = (t1 >= N4) ? t1 - N4 : t1;
      t3 = (t2 >= N2) ? t2 - N2 : t2;
      t4 = (t3 >= N1) ? t3 - N1 : t3;
      rem_next = t4[SW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        running <= 1'b0;
        done_r  <= 1'b0;
        cnt     <= '0;
      end else begin
        done_r <= running && (cnt == LAST);
        if (start) begin
          running <= 1'b1;
          cnt     <= '0;
        end else if (running) begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            running <= 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        xs  <= XW'(pc_word);
        rem <= '0;
      end else if (running) begin
        xs  <= xs << 4;
        rem <= rem_next;
      end
    end

    assign done = done_r;
    assign slot = rem;

  end

endmodule

`default_nettype wire

[rtl/branch_predictor_btb_one_two_bit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Branch target buffer with a selectable one-bit or two-bit direction predictor.
// A transaction is accepted when start is high and busy is low; its result is
// driven on rsp with done high for exactly one cycle and cannot be held off.
// With TABLE_ENTRIES a power of two an item is one synchronous table read, then
// the write-back that also registers the result and raises done. Otherwise the
// slot is found first by a remainder unit, and only then is the table read.
// After reset busy stays high while the table is cleared, one entry a cycle;
// cfg_ready is low while busy or start is high, so the mode only changes
// between transactions.

`include "branch_predictor_btb_one_two_bit_assert.svh"

module branch_predictor_btb_one_two_bit #(
  parameter int unsigned TABLE_ENTRIES = bpbtb_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire bpbtb_pkg::req_t  req,
  output logic                  done,
  output bpbtb_pkg::rsp_t       rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_data
);

  import bpbtb_pkg::*;

  localparam int unsigned SW = $clog2(TABLE_ENTRIES);
  localparam int unsigned EW = $bits(entry_t);
  localparam logic [SW-1:0] CLR_LAST = SW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_INDEX  = 4'b0100,
    S_LOOKUP = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [1:0]    mode;
  logic [SW-1:0] clr_addr;
  req_t          req_q;
  logic [SW-1:0] slot_q;

  logic          accept;
  logic          slot_done;
  logic [SW-1:0] slot;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  entry_t        rd_entry;
  entry_t        wr_entry;
  logic          hit;
  logic [1:0]    cur;
  logic [1:0]    ctr_next;
  logic          active;
  logic          pred;
  rsp_t          rsp_next;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;

  bpbtb_slot #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_slot (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .pc_word (req.branch_pc[31:PC_SHIFT]),
    .done    (slot_done),
    .slot    (slot)
  );

  bpbtb_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_entry = entry_t'(ram_rdata);
    hit      = rd_entry.valid && (rd_entry.tag == req_q.branch_pc);
    cur      = hit ? rd_entry.ctr : CTR_STRONG_NT;
    active   = (mode == MODE_ONE_BIT) || (mode == MODE_TWO_BIT);
    pred     = active && cur[1];

    if (mode == MODE_ONE_BIT) begin
      ctr_next = req_q.taken_outcome ? CTR_STRONG_T : CTR_STRONG_NT;
    end else if (req_q.taken_outcome) begin
      ctr_next = (cur == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
    end else begin
      ctr_next = (cur == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
    end

    wr_entry.valid  = 1'b1;
    wr_entry.tag    = req_q.branch_pc;
    wr_entry.target = req_q.branch_target;
    wr_entry.ctr    = ctr_next;

    rsp_next.predicted_taken  = pred;
    rsp_next.entry_hit        = hit;
    rsp_next.predicted_target = hit ? rd_entry.target : '0;
    rsp_next.flush_needed     = pred != req_q.taken_outcome;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = EW'(wr_entry);
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_LOOKUP) begin
      ram_we = active;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = slot_done ? S_LOOKUP : S_INDEX;
      end
      S_INDEX: begin
        if (slot_done) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      mode     <= MODE_NONE;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_LOOKUP);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (slot_done) begin
      slot_q <= slot;
    end
    if (state == S_LOOKUP) begin
      rsp <= rsp_next;
    end
  end

  `BPB_ASSERT_NEXT(a_lookup_done, state == S_LOOKUP, done, "lookup gave no result")
  `BPB_ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after a transaction")
  `BPB_ASSERT_NOW(a_idle_no_write, state == S_IDLE, !ram_we, "table written while idle")
  `BPB_ASSERT_NOW(a_miss_clean, done && !rsp.entry_hit,
                  !rsp.predicted_taken && (rsp.predicted_target == '0),
                  "miss reported a prediction")

endmodule

`default_nettype wire

[test/branch_predictor_btb_one_two_bit_test.sv]
`timescale 1ns / 1ps

module branch_predictor_btb_one_two_bit_test;
  import bpbtb_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned HOT_BRANCHES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t branch_req = '0;
  logic done;
  rsp_t branch_rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = MODE_NONE;

  req_t branch_q[$];
  rsp_t outcome_q[$];
  rsp_t oldest_rsp;
  logic branch_accepted = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned failures = 0;

  logic [1:0] btb_mode;
  logic btb_valid [TABLE_ENTRIES_DEF];
  logic [31:0] btb_tag [TABLE_ENTRIES_DEF];
  logic [31:0] btb_target [TABLE_ENTRIES_DEF];
  logic [1:0] btb_ctr [TABLE_ENTRIES_DEF];

  logic [31:0] hot_pc [HOT_BRANCHES];
  logic [31:0] hot_target [HOT_BRANCHES];
  int unsigned hot_bias [HOT_BRANCHES];

  branch_predictor_btb_one_two_bit u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(branch_req),
    .done(done),
    .rsp(branch_rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rsp_t predict_branch(req_t r);
    int unsigned slot;
    logic hit;
    logic enabled;
    logic [1:0] ctr;
    rsp_t p;
    slot = (r.branch_pc >> PC_SHIFT) % TABLE_ENTRIES_DEF;
    hit = btb_valid[slot] && (btb_tag[slot] == r.branch_pc);
    ctr = hit ? btb_ctr[slot] : CTR_STRONG_NT;
    enabled = (btb_mode == MODE_ONE_BIT) || (btb_mode == MODE_TWO_BIT);
    p.predicted_taken = enabled && ctr[1];
    p.entry_hit = hit;
    p.predicted_target = hit ? btb_target[slot] : 32'd0;
    p.flush_needed = p.predicted_taken != r.taken_outcome;
    if (enabled) begin
      if (btb_mode == MODE_ONE_BIT) begin
        btb_ctr[slot] = r.taken_outcome ? CTR_STRONG_T : CTR_STRONG_NT;
      end else if (r.taken_outcome) begin
        btb_ctr[slot] = (ctr == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
      end else begin
        btb_ctr[slot] = (ctr == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
      end
      btb_valid[slot] = 1'b1;
      btb_tag[slot] = r.branch_pc;
      btb_target[slot] = r.branch_target;
    end
    return p;
  endfunction

  task automatic compare_result(rsp_t exp_rsp, rsp_t got);
    if (got.predicted_taken !== exp_rsp.predicted_taken) begin
      $error("predicted_taken: expected %0d, got %0d", exp_rsp.predicted_taken,
             got.predicted_taken);
      failures++;
    end
    if (got.entry_hit !== exp_rsp.entry_hit) begin
      $error("entry_hit: expected %0d, got %0d", exp_rsp.entry_hit, got.entry_hit);
      failures++;
    end
    if (got.predicted_target !== exp_rsp.predicted_target) begin
      $error("predicted_target: expected %h, got %h", exp_rsp.predicted_target,
             got.predicted_target);
      failures++;
    end
    if (got.flush_needed !== exp_rsp.flush_needed) begin
      $error("flush_needed: expected %0d, got %0d", exp_rsp.flush_needed,
             got.flush_needed);
      failures++;
    end
  endtask

  // monitor: results, mode writes and accepted transactions
  always @(posedge clk) begin
    if (rst) begin
      branch_accepted <= 1'b0;
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no transaction outstanding");
          failures++;
        end else begin
          oldest_rsp = outcome_q.pop_front();
          compare_result(oldest_rsp, branch_rsp);
        end
      end
      if (cfg_valid && cfg_ready) begin
        btb_mode = cfg_data;
      end
      if (start && !busy) begin
        outcome_q.push_back(predict_branch(branch_req));
      end
      branch_accepted <= start && !busy;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || branch_accepted) begin
      if (branch_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        branch_req <= branch_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_branch(logic [31:0] pc, logic [31:0] tgt, logic tk);
    req_t r;
    r.branch_pc = pc;
    r.branch_target = tgt;
    r.taken_outcome = tk;
    branch_q.push_back(r);
  endtask

  // checked just after the driver has settled, start high means still offered
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (branch_q.size() != 0 || outcome_q.size() != 0 || start);
  endtask

  task automatic write_mode(logic [1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random_branches(int unsigned n);
    int unsigned pick;
    int unsigned h;
    logic [31:0] pc;
    logic [31:0] tgt;
    logic tk;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      h = $urandom_range(HOT_BRANCHES - 1);
      if (pick < 70) begin
        pc = hot_pc[h];
        tgt = ($urandom_range(3) == 0) ? $urandom : hot_target[h];
        tk = $urandom_range(99) < hot_bias[h];
      end else if (pick < 85) begin
        // same slot, different tag
        pc = hot_pc[h] ^ ($urandom & 32'hFFFF_FE07);
        tgt = $urandom;
        tk = $urandom_range(1);
      end else begin
        pc = $urandom;
        tgt = $urandom;
        tk = $urandom_range(1);
      end
      queue_branch(pc, tgt, tk);
    end
  endtask

  task automatic run_phase(logic [1:0] m, int unsigned idle_pct, int unsigned n);
    drain();
    sender_idle_pct = idle_pct;
    write_mode(m);
    queue_random_branches(n);
  endtask

  initial begin
    for (int unsigned i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      btb_valid[i] = 1'b0;
      btb_tag[i] = '0;
      btb_target[i] = '0;
      btb_ctr[i] = CTR_STRONG_NT;
    end
    btb_mode = MODE_NONE;
    for (int unsigned i = 0; i < HOT_BRANCHES; i++) begin
      hot_pc[i] = $urandom;
      hot_target[i] = $urandom;
      case (i % 4)
        0: hot_bias[i] = 92;
        1: hot_bias[i] = 8;
        2: hot_bias[i] = 50;
        default: hot_bias[i] = 75;
      endcase
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_mode(MODE_NONE);
    queue_branch(32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    drain();
    write_mode(MODE_TWO_BIT);
    queue_branch(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    queue_branch(32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_branch(32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_branch(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_branch(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_branch(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_branch(32'h0000_0200, 32'h1234_5678, 1'b1);
    queue_branch(32'h0000_0007, 32'hA5A5_A5A5, 1'b1);
    queue_branch(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    queue_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    drain();
    write_mode(MODE_ONE_BIT);
    queue_branch(32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0);
    queue_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_branch(32'h0000_0007, 32'h0000_0000, 1'b0);

    drain();
    write_mode(MODE_NONE);
    queue_branch(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    queue_branch(32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b0);

    drain();
    write_mode(MODE_UNUSED);
    queue_branch(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    queue_branch(32'h0000_0007, 32'h8000_0000, 1'b1);

    run_phase(MODE_TWO_BIT, 0, 130);
    run_phase(MODE_ONE_BIT, 77, 130);
    run_phase(MODE_TWO_BIT, 34, 130);
    run_phase(MODE_NONE, 77, 130);
    run_phase(MODE_TWO_BIT, 77, 130);
    run_phase(MODE_UNUSED, 0, 130);
    run_phase(MODE_ONE_BIT, 34, 130);
    run_phase(MODE_TWO_BIT, 0, 130);

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("branch_predictor_btb_one_two_bit regression: pass");
    end else begin
      $display("branch_predictor_btb_one_two_bit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("branch_predictor_btb_one_two_bit regression: fail");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/bpbtb_pkg.sv
rtl/bpbtb_ram.sv
rtl/bpbtb_slot.sv
rtl/branch_predictor_btb_one_two_bit.sv
test/branch_predictor_btb_one_two_bit_test.sv
